/* hdl/naa_pkg.sv */
// Shared types and constants for the node address allocator.
package naa_pkg;

  localparam int ADDR_W = 8;
  localparam int EP_W   = 4;
  localparam int TYPE_W = 8;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_ACCEPT = 2'd1,
    FUNC_SLEEP  = 2'd2,
    FUNC_WAKE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REPLY_OFFER = 2'd0,
    REPLY_ACK   = 2'd1,
    REPLY_NONE  = 2'd2,
    REPLY_FULL  = 2'd3
  } reply_t;

  typedef enum logic [4:0] {
    ST_CLEAR    = 5'b00001,
    ST_IDLE     = 5'b00010,
    ST_EXEC     = 5'b00100,
    ST_SCAN_RD  = 5'b01000,
    ST_SCAN_CHK = 5'b10000
  } state_t;

  // One table entry: flags plus the recorded endpoint and sensor type.
  typedef struct packed {
    logic              in_use;
    logic              sleeping;
    logic [EP_W-1:0]   endpoint;
    logic [TYPE_W-1:0] sensor;
  } entry_t;

  // Commands from the sequencer to the scan unit.
  typedef struct packed {
    logic load;
    logic advance;
  } scan_ctrl_t;

endpackage

/* hdl/naa_ram.sv */
// Generic single-port-write, registered-read RAM.
module naa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/naa_scan.sv */
// Scan unit: walks the table index forward with wrap and counts the steps taken.
module naa_scan #(
  parameter int DEPTH = 256,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  naa_pkg::scan_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    start_idx,
  output logic [IDX_W-1:0]    cur_idx,
  output logic                last
);

  import naa_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] cur_idx_next;
  logic [IDX_W-1:0] start_next;

  always_comb begin
    start_next   = (start_idx == LAST_IDX) ? '0 : start_idx + IDX_W'(1);
    cur_idx_next = (cur_idx == LAST_IDX) ? '0 : cur_idx + IDX_W'(1);
  end

  // Every entry has been looked at once the count reaches the last step.
  assign last = (cnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cur_idx <= start_next;
      cnt     <= '0;
    end else if (ctrl.advance) begin
      cur_idx <= cur_idx_next;
      cnt     <= cnt + IDX_W'(1);
    end
  end

endmodule

/* hdl/node_address_allocator.sv */
// Node address allocator: top level with sequencer, entry table and result register.
//
// Hands out node addresses from a table of TABLE_DEPTH entries. Each transaction
// carries an operation (allocate, accept, sleep, wake) and gives exactly one result.
// The entry table sits in a RAM with registered read; after reset a clearing pass
// writes every entry once, and the input is stalled until that pass is done.
// Accept, sleep and wake read the entry and write it back.
// Allocate walks the in-use flags with a single shared index/compare unit, starting
// just past the search pointer; each entry looked at is read, then tested, and the
// first free entry is offered. A full table answers "table full" after TABLE_DEPTH
// entries and leaves the search pointer alone. Execution and each entry test wait
// while the result register is stalled.
// The input is stalled while a transaction is at work; a finished result waits in
// the output register while the next transaction is taken in.
module node_address_allocator #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  func,
  input  logic [naa_pkg::ADDR_W-1:0]  src_addr,
  input  logic [naa_pkg::EP_W-1:0]    src_endpoint,
  input  logic [naa_pkg::TYPE_W-1:0]  sensor_type,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  reply,
  output logic [naa_pkg::ADDR_W-1:0]  reply_addr
);

  import naa_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t state;
  state_t state_next;

  func_t               func_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [EP_W-1:0]     ep_q;
  logic [TYPE_W-1:0]   type_q;
  logic                addr_ok_q;

  logic [IDX_W-1:0]       search_ptr;
  logic [IDX_W-1:0]       clr_idx;

  reply_t            reply_q;
  reply_t            reply_next;
  logic [ADDR_W-1:0] reply_addr_next;

  scan_ctrl_t       scan_ctrl;
  logic [IDX_W-1:0] cur_idx;
  logic             scan_last;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  logic             accept_in;
  logic             out_free;
  logic             exec_done;
  logic             hit;
  logic             full;
  logic             load_result;
  logic [IDX_W-1:0] addr_idx;

  assign in_stall  = (state != ST_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign addr_idx  = addr_q[IDX_W-1:0];

  naa_scan #(
    .DEPTH(TABLE_DEPTH)
  ) u_scan (
    .clk       (clk),
    .ctrl      (scan_ctrl),
    .start_idx (search_ptr),
    .cur_idx   (cur_idx),
    .last      (scan_last)
  );

  // Flags, endpoint and sensor type of every entry.
  naa_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_next      = state;
    scan_ctrl       = '0;
    exec_done       = 1'b0;
    hit             = 1'b0;
    full            = 1'b0;
    reply_next      = REPLY_NONE;
    reply_addr_next = '0;
    ram_we          = 1'b0;
    ram_waddr       = cur_idx;
    ram_wdata       = '0;
    ram_raddr       = cur_idx;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        if (clr_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // Read the addressed entry while the transaction is taken in.
        ram_raddr = src_addr[IDX_W-1:0];
        if (accept_in) begin
          if (func_t'(func) == FUNC_ALLOC) begin
            scan_ctrl.load = 1'b1;
            state_next     = ST_SCAN_RD;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        ram_raddr = addr_idx;
        ram_waddr = addr_idx;
        ram_wdata = ram_rdata;
        unique case (func_q)
          FUNC_ACCEPT: ram_wdata.in_use   = 1'b1;
          FUNC_SLEEP:  ram_wdata.sleeping = 1'b1;
          default:     ram_wdata.sleeping = 1'b0;
        endcase
        if (out_free) begin
          exec_done  = 1'b1;
          ram_we     = addr_ok_q;
          state_next = ST_IDLE;
          if (addr_ok_q && func_q == FUNC_ACCEPT) begin
            reply_next      = REPLY_ACK;
            reply_addr_next = addr_q;
          end
        end
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        // Hold the scan until the result register is free.
        if (out_free) begin
          if (!ram_rdata.in_use) begin
            hit                = 1'b1;
            ram_we             = 1'b1;
            ram_wdata.endpoint = ep_q;
            ram_wdata.sensor   = type_q;
            reply_next         = REPLY_OFFER;
            reply_addr_next    = ADDR_W'(cur_idx);
            state_next         = ST_IDLE;
          end else if (scan_last) begin
            full       = 1'b1;
            reply_next = REPLY_FULL;
            state_next = ST_IDLE;
          end else begin
            scan_ctrl.advance = 1'b1;
            state_next        = ST_SCAN_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign load_result = exec_done || hit || full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      search_ptr <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (hit) begin
        search_ptr <= cur_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      func_q    <= func_t'(func);
      addr_q    <= src_addr;
      ep_q      <= src_endpoint;
      type_q    <= sensor_type;
      addr_ok_q <= ({1'b0, src_addr} < (ADDR_W + 1)'(TABLE_DEPTH));
    end
    if (load_result) begin
      reply_q    <= reply_next;
      reply_addr <= reply_addr_next;
    end
  end

  assign reply = reply_q;

`ifndef SYNTHESIS
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(reply_q) && $stable(reply_addr))
    else $error("stalled result changed");

  a_addr_in_table: assert property (@(posedge clk) disable iff (rst)
    out_valid && (reply_q == REPLY_OFFER || reply_q == REPLY_ACK)
      |-> ({1'b0, reply_addr} < (ADDR_W + 1)'(TABLE_DEPTH)))
    else $error("reply address beyond the table");

  a_no_addr_without_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid && (reply_q == REPLY_NONE || reply_q == REPLY_FULL) |-> reply_addr == '0)
    else $error("address given without an offer or acknowledge");

  a_ptr_moves_on_offer: assert property (@(posedge clk) disable iff (rst)
    !$stable(search_ptr) |-> out_valid && reply_q == REPLY_OFFER
      && reply_addr == ADDR_W'(search_ptr))
    else $error("search pointer moved without an offer");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the node address allocator.
`timescale 1ns / 1ps

module testbench;
  import naa_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int N_DIRECTED  = 20;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 232;

  typedef struct packed {
    reply_t              code;
    logic [ADDR_W-1:0]   addr;
  } reply_rec_t;

  typedef struct packed {
    func_t               op;
    logic [ADDR_W-1:0]   addr;
    logic [EP_W-1:0]     ep;
    logic [TYPE_W-1:0]   stype;
    logic                fixed;
    reply_t              code;
    logic [ADDR_W-1:0]   raddr;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          func = FUNC_WAKE;
  logic [ADDR_W-1:0]   src_addr = '0;
  logic [EP_W-1:0]     src_endpoint = '0;
  logic [TYPE_W-1:0]   sensor_type = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          reply;
  logic [ADDR_W-1:0]   reply_addr;

  // Allocator mirror
  bit                  node_in_use [TABLE_DEPTH];
  bit                  node_asleep [TABLE_DEPTH];
  logic [EP_W-1:0]     node_ep     [TABLE_DEPTH];
  logic [TYPE_W-1:0]   node_type   [TABLE_DEPTH];
  int unsigned         search_ptr = 0;

  reply_rec_t          pending_replies[$];
  reply_t              last_code;
  logic [ADDR_W-1:0]   last_addr;
  int                  errors = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;

  int                  send_idle_by_phase [4] = '{0, 66, 0, 21};
  int                  recv_stall_by_phase[4] = '{0, 0, 66, 21};

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{FUNC_ALLOC,  8'h00, 4'h0, 8'h00, 1'b1, REPLY_OFFER, 8'd1},
    '{FUNC_ALLOC,  8'hff, 4'hf, 8'hff, 1'b1, REPLY_OFFER, 8'd2},
    '{FUNC_ACCEPT, 8'hff, 4'h0, 8'h00, 1'b1, REPLY_ACK,   8'hff},
    '{FUNC_ACCEPT, 8'h00, 4'hf, 8'hff, 1'b1, REPLY_ACK,   8'h00},
    '{FUNC_ACCEPT, 8'h03, 4'h0, 8'h00, 1'b1, REPLY_ACK,   8'h03},
    '{FUNC_ACCEPT, 8'h03, 4'h5, 8'ha5, 1'b1, REPLY_ACK,   8'h03},
    '{FUNC_ALLOC,  8'h5a, 4'ha, 8'h5a, 1'b0, REPLY_OFFER, 8'h00},
    '{FUNC_SLEEP,  8'hff, 4'hf, 8'hff, 1'b1, REPLY_NONE,  8'h00},
    '{FUNC_SLEEP,  8'h00, 4'h0, 8'h00, 1'b1, REPLY_NONE,  8'h00},
    '{FUNC_WAKE,   8'hff, 4'hf, 8'hff, 1'b1, REPLY_NONE,  8'h00},
    '{FUNC_WAKE,   8'h00, 4'h0, 8'h00, 1'b1, REPLY_NONE,  8'h00},
    '{FUNC_SLEEP,  8'h04, 4'h3, 8'h3c, 1'b1, REPLY_NONE,  8'h00},
    '{FUNC_ALLOC,  8'h00, 4'h7, 8'h80, 1'b0, REPLY_OFFER, 8'h00},
    '{FUNC_ACCEPT, 8'h05, 4'h0, 8'h00, 1'b1, REPLY_ACK,   8'h05},
    '{FUNC_ACCEPT, 8'h06, 4'h0, 8'h00, 1'b1, REPLY_ACK,   8'h06},
    '{FUNC_ACCEPT, 8'h07, 4'h0, 8'h00, 1'b1, REPLY_ACK,   8'h07},
    '{FUNC_ALLOC,  8'h00, 4'h8, 8'h7f, 1'b0, REPLY_OFFER, 8'h00},
    '{FUNC_WAKE,   8'h80, 4'h0, 8'h00, 1'b1, REPLY_NONE,  8'h00},
    '{FUNC_ACCEPT, 8'h80, 4'h0, 8'h00, 1'b1, REPLY_ACK,   8'h80},
    '{FUNC_ACCEPT, 8'h7f, 4'h0, 8'h00, 1'b1, REPLY_ACK,   8'h7f}
  };

  node_address_allocator #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .src_addr     (src_addr),
    .src_endpoint (src_endpoint),
    .sensor_type  (sensor_type),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .reply        (reply),
    .reply_addr   (reply_addr)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Apply one transaction to the mirror and return the reply it must give.
  function automatic reply_rec_t allocate_or_mark(input func_t op, input logic [ADDR_W-1:0] addr,
                                                  input logic [EP_W-1:0] ep,
                                                  input logic [TYPE_W-1:0] stype);
    reply_rec_t  rec;
    int unsigned idx;
    bit          found;
    rec.code = REPLY_NONE;
    rec.addr = '0;
    found = 1'b0;
    if (op == FUNC_ALLOC) begin
      idx = (search_ptr + 1) % TABLE_DEPTH;
      for (int n = 0; n < TABLE_DEPTH && !found; n++) begin
        if (!node_in_use[idx]) found = 1'b1;
        else idx = (idx + 1) % TABLE_DEPTH;
      end
      if (found) begin
        search_ptr = idx;
        node_ep[idx] = ep;
        node_type[idx] = stype;
        node_asleep[idx] = 1'b0;
        rec.code = REPLY_OFFER;
        rec.addr = idx[ADDR_W-1:0];
      end else begin
        rec.code = REPLY_FULL;
      end
    end else if (addr < TABLE_DEPTH) begin
      case (op)
        FUNC_ACCEPT: begin
          node_in_use[addr] = 1'b1;
          rec.code = REPLY_ACK;
          rec.addr = addr;
        end
        FUNC_SLEEP: node_asleep[addr] = 1'b1;
        default: node_asleep[addr] = 1'b0;
      endcase
    end
    return rec;
  endfunction

  task automatic send_txn(input func_t op, input logic [ADDR_W-1:0] addr,
                          input logic [EP_W-1:0] ep, input logic [TYPE_W-1:0] stype,
                          input logic fixed, input reply_rec_t fixed_rec);
    int         gap;
    reply_rec_t rec;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= op;
    src_addr     <= addr;
    src_endpoint <= ep;
    sensor_type  <= stype;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rec = allocate_or_mark(op, addr, ep, stype);
    last_code = rec.code;
    last_addr = rec.addr;
    // Hand-typed rows override the mirror; the mirror state still advances.
    if (fixed) pending_replies.push_back(fixed_rec);
    else pending_replies.push_back(rec);
  endtask

  always @(posedge clk) begin : reply_checker
    reply_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, got reply=%0d reply_addr=%0d",
                 $time, reply, reply_addr);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (reply !== want.code) begin
          $display("%0t: reply mismatch, expected %0d, got %0d", $time, want.code, reply);
          errors++;
        end
        if (reply_addr !== want.addr) begin
          $display("%0t: reply_addr mismatch, expected %0d, got %0d",
                   $time, want.addr, reply_addr);
          errors++;
        end
      end
    end
  end

  initial begin
    reply_rec_t  rec;
    func_t       op;
    logic [7:0]  addr;
    bit          offer_open;
    int unsigned roll;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      rec.code = directed_rows[i].code;
      rec.addr = directed_rows[i].raddr;
      send_txn(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].ep,
               directed_rows[i].stype, directed_rows[i].fixed, rec);
    end

    offer_open = 1'b0;
    rec = '0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      send_idle_pct  = send_idle_by_phase[ph % 4];
      recv_stall_pct = recv_stall_by_phase[ph % 4];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(99);
        addr = ADDR_W'($urandom_range(255));
        // Mostly allocate followed by accept of the offered address; the rest is noise.
        if (offer_open && roll < 35) begin
          op = FUNC_ACCEPT;
          addr = last_addr;
        end else if (roll < 75) begin
          op = FUNC_ALLOC;
        end else if (roll < 80) begin
          op = FUNC_ACCEPT;
        end else if (roll < 90) begin
          op = FUNC_SLEEP;
        end else begin
          op = FUNC_WAKE;
        end
        send_txn(op, addr, EP_W'($urandom_range(15)), TYPE_W'($urandom_range(255)),
                 1'b0, rec);
        offer_open = (op == FUNC_ALLOC) && (last_code == REPLY_OFFER);
      end
    end
    in_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
